>>> design/hcsd_pkg.sv
// Shared widths, limits and sequencer state codes for the histogram distance core.
package hcsd_pkg;

  localparam int unsigned BIN_W     = 16;             // Q0.16 bin value
  localparam int unsigned BSUM_W    = BIN_W + 1;      // a+b, Q1.16
  localparam int unsigned SQ_W      = 2 * BIN_W;      // (a-b)^2, Q0.32
  localparam int unsigned SUM_W     = 25;             // running sum, Q9.16
  localparam int unsigned DIV_STEPS = BIN_W;          // quotient bits per term
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Distance mode codes
  localparam logic MODE_L1  = 1'b0;
  localparam logic MODE_CHI = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SQUARE = 4'b0010,
    ST_DIVIDE = 4'b0100,
    ST_ACCUM  = 4'b1000
  } state_e;

endpackage

>>> design/hcsd_ifs.sv
// Valid/ready channel interfaces for bin pairs in and distance totals out.
interface hcsd_pair_if
  import hcsd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [BIN_W-1:0] bin_a;
  logic [BIN_W-1:0] bin_b;
  logic             last_bin;

  modport source (output valid, output bin_a, output bin_b, output last_bin, input ready);
  modport sink   (input valid, input bin_a, input bin_b, input last_bin, output ready);
endinterface

interface hcsd_dist_if
  import hcsd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] distance;

  modport source (output valid, output distance, input ready);
  modport sink   (input valid, input distance, output ready);
endinterface

>>> design/histogram_chi_square_distance_core.sv
// Histogram chi-square / L1 distance accumulator with a shared restoring divider.
//
//  channel   dir  payload                          transfer when
//  pair_i    in   bin_a[15:0] bin_b[15:0] last_bin  valid & ready
//  dist_o    out  distance[24:0]                    valid & ready
//  cfg       in   cfg_data_i[0] (distance_mode)     cfg_we_i
//
//  Chi-square item: square, then 16 iterations of the single restoring divider
//  step, then accumulate, before the next ready. L1 item: square and accumulate.
//  Zero pair in chi-square mode skips the divider.
//  Reset (rst_ni low, asynchronous) clears the sum, sets chi-square mode and
//  empties the output register. A stalled result holds in the output register
//  while the next item is taken; only a last item waits for it to drain.
module histogram_chi_square_distance_core
  import hcsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_data_i,
  hcsd_pair_if.sink   pair_i,
  hcsd_dist_if.source dist_o
);

  // Control state
  state_e             state_q, state_d;
  logic               mode_reg_q, mode_reg_d;   // configured mode
  logic [SUM_W-1:0]   sum_q, sum_d;             // running sum
  logic [CNT_W-1:0]   cnt_q, cnt_d;             // divider step
  logic               out_valid_q, out_valid_d;

  // Item and datapath registers (no reset)
  logic [BIN_W-1:0]   a_q, a_d;
  logic [BIN_W-1:0]   b_q, b_d;
  logic               last_q, last_d;
  logic               mode_q, mode_d;           // mode latched per item
  logic [BSUM_W-1:0]  div_q, div_d;             // divisor a+b
  logic [BSUM_W-1:0]  rem_q, rem_d;             // partial remainder
  logic [BIN_W-1:0]   lo_q, lo_d;               // dividend low bits / quotient / term
  logic [SUM_W-1:0]   out_q, out_d;

  // Datapath
  logic [BIN_W-1:0]   diff;
  logic [BSUM_W-1:0]  bsum;
  logic [SQ_W-1:0]    sq;
  logic [BSUM_W:0]    trial;
  logic               trial_ge;
  logic [BSUM_W:0]    trial_sub;
  logic [SUM_W:0]     acc;
  logic [SUM_W-1:0]   acc_sat;
  logic               pair_xfer;
  logic               out_free;

  assign pair_i.ready    = (state_q == ST_IDLE);
  assign pair_xfer       = pair_i.valid & pair_i.ready;
  assign dist_o.valid    = out_valid_q;
  assign dist_o.distance = out_q;
  assign out_free        = ~out_valid_q | dist_o.ready;

  // Absolute difference, sum and square of the held pair
  assign diff = (a_q > b_q) ? (a_q - b_q) : (b_q - a_q);
  assign bsum = {1'b0, a_q} + {1'b0, b_q};
  assign sq   = SQ_W'(diff) * SQ_W'(diff);

  // One restoring division step: bring down the next dividend bit
  assign trial     = {rem_q, lo_q[BIN_W-1]};
  assign trial_ge  = (trial >= {1'b0, div_q});
  assign trial_sub = trial - {1'b0, div_q};

  // Accumulate with saturation
  assign acc     = {1'b0, sum_q} + (SUM_W + 1)'(lo_q);
  assign acc_sat = acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];

  always_comb begin
    state_d     = state_q;
    mode_reg_d  = mode_reg_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    a_d         = a_q;
    b_d         = b_q;
    last_d      = last_q;
    mode_d      = mode_q;
    div_d       = div_q;
    rem_d       = rem_q;
    lo_d        = lo_q;
    out_d       = out_q;

    if (cfg_we_i) begin
      mode_reg_d = cfg_data_i;
    end

    // Result leaves on its transfer; may be reloaded below in the same cycle
    if (out_valid_q && dist_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (pair_xfer) begin
          a_d     = pair_i.bin_a;
          b_d     = pair_i.bin_b;
          last_d  = pair_i.last_bin;
          mode_d  = mode_reg_q;
          state_d = ST_SQUARE;
        end
      end

      ST_SQUARE: begin
        if (mode_q == MODE_L1) begin
          lo_d    = diff;
          state_d = ST_ACCUM;
        end else if (bsum == '0) begin
          // empty pair adds nothing
          lo_d    = '0;
          state_d = ST_ACCUM;
        end else begin
          // quotient fits BIN_W bits, so the top half is already below a+b
          rem_d   = BSUM_W'(sq[SQ_W-1:BIN_W]);
          lo_d    = sq[BIN_W-1:0];
          div_d   = bsum;
          cnt_d   = '0;
          state_d = ST_DIVIDE;
        end
      end

      ST_DIVIDE: begin
        rem_d = trial_ge ? trial_sub[BSUM_W-1:0] : trial[BSUM_W-1:0];
        lo_d  = {lo_q[BIN_W-2:0], trial_ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_ACCUM;
        end
      end

      ST_ACCUM: begin
        if (!last_q) begin
          sum_d   = acc_sat;
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_d       = acc_sat;
          out_valid_d = 1'b1;
          sum_d       = '0;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_reg_q  <= MODE_CHI;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_reg_q  <= mode_reg_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    last_q <= last_d;
    mode_q <= mode_d;
    div_q  <= div_d;
    rem_q  <= rem_d;
    lo_q   <= lo_d;
    out_q  <= out_d;
  end

endmodule

>>> design/hcsd_checker.sv
// Port-level assertions for the histogram distance core, bound to the top level.
module hcsd_checker
  import hcsd_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             pair_valid_i,
  input logic             pair_ready_i,
  input logic             dist_valid_i,
  input logic             dist_ready_i,
  input logic [SUM_W-1:0] dist_distance_i
);

  // Stalled result holds its value
  a_dist_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_valid_i && !dist_ready_i |=> dist_valid_i && $stable(dist_distance_i))
    else $error("stalled distance changed or dropped");

  // An item keeps the core busy for at least the square and accumulate steps
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_valid_i && pair_ready_i |=> !pair_ready_i ##1 !pair_ready_i)
    else $error("input ready too soon after transfer");

  // A new result only appears out of item work
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(dist_valid_i) |-> !$past(pair_ready_i))
    else $error("result appeared while idle");

  // Output register is reloaded only once the previous result has gone
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_valid_i && !dist_ready_i |=> !$rose(pair_ready_i) || !dist_valid_i ||
      $stable(dist_distance_i))
    else $error("pending result overwritten");

endmodule

bind histogram_chi_square_distance_core hcsd_checker u_hcsd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .pair_valid_i    (pair_i.valid),
  .pair_ready_i    (pair_i.ready),
  .dist_valid_i    (dist_o.valid),
  .dist_ready_i    (dist_o.ready),
  .dist_distance_i (dist_o.distance)
);
